// ----- hdl/biq_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// biq_pkg
// Shared types and constants for the direct form 1 biquad filter unit.
// ============================================================================
package biq_pkg;

    // Coefficient format: signed Q2.16.
    localparam int COEF_WIDTH = 18;
    localparam int COEF_FRAC  = 16;

    // Configuration register index.
    localparam int CFG_INDEX_WIDTH = 3;

    // Parameter defaults.
    localparam int DEF_CHANNELS     = 4;
    localparam int DEF_SAMPLE_WIDTH = 16;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_COEF_B0 = 3'd0,
        CFG_COEF_B1 = 3'd1,
        CFG_COEF_B2 = 3'd2,
        CFG_COEF_A1 = 3'd3,
        CFG_COEF_A2 = 3'd4
    } t_cfg_index;

    typedef logic signed [COEF_WIDTH-1:0] t_coef;

    typedef struct packed {
        t_coef b0;
        t_coef b1;
        t_coef b2;
        t_coef a1;
        t_coef a2;
    } t_coefs;

    localparam t_coef COEF_B0_RESET = t_coef'(65536);
    localparam t_coef COEF_ZERO     = t_coef'(0);

endpackage

// ----- hdl/biq_coef_regs.sv -----
`timescale 1ns / 1ps
// ============================================================================
// biq_coef_regs
// Holds the five filter coefficients and decodes configuration writes.
// ============================================================================
module biq_coef_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_en,
    input  logic [biq_pkg::CFG_INDEX_WIDTH-1:0] i_wr_index,
    input  logic [biq_pkg::COEF_WIDTH-1:0]      i_wr_data,
    output biq_pkg::t_coefs                     o_coefs
);
    import biq_pkg::*;

    t_coefs r_coefs;

    // Writes to an index beyond the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0 <= COEF_B0_RESET;
            r_coefs.b1 <= COEF_ZERO;
            r_coefs.b2 <= COEF_ZERO;
            r_coefs.a1 <= COEF_ZERO;
            r_coefs.a2 <= COEF_ZERO;
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_COEF_B0: r_coefs.b0 <= t_coef'(i_wr_data);
                CFG_COEF_B1: r_coefs.b1 <= t_coef'(i_wr_data);
                CFG_COEF_B2: r_coefs.b2 <= t_coef'(i_wr_data);
                CFG_COEF_A1: r_coefs.a1 <= t_coef'(i_wr_data);
                CFG_COEF_A2: r_coefs.a2 <= t_coef'(i_wr_data);
                default: ;
            endcase
        end
    end

    assign o_coefs = r_coefs;

endmodule

// ----- hdl/biq_history.sv -----
`timescale 1ns / 1ps
// ============================================================================
// biq_history
// Per-channel history of the last two inputs and outputs, with priming.
// ============================================================================
module biq_history #(
    parameter int CHANNELS     = biq_pkg::DEF_CHANNELS,
    parameter int SAMPLE_WIDTH = biq_pkg::DEF_SAMPLE_WIDTH,
    parameter int CH_WIDTH     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [CH_WIDTH-1:0]            i_channel,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x,
    input  logic                           i_wr_en,
    input  logic signed [SAMPLE_WIDTH-1:0] i_wr_y,
    output logic signed [SAMPLE_WIDTH-1:0] o_x1,
    output logic signed [SAMPLE_WIDTH-1:0] o_x2,
    output logic signed [SAMPLE_WIDTH-1:0] o_y1,
    output logic signed [SAMPLE_WIDTH-1:0] o_y2
);
    import biq_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] r_x1 [CHANNELS];
    logic signed [SAMPLE_WIDTH-1:0] r_x2 [CHANNELS];
    logic signed [SAMPLE_WIDTH-1:0] r_y1 [CHANNELS];
    logic signed [SAMPLE_WIDTH-1:0] r_y2 [CHANNELS];
    logic [CHANNELS-1:0]            r_primed;

    // A channel that has not seen a sample yet reads its whole history as
    // the current sample.
    always_comb begin
        if (r_primed[i_channel]) begin
            o_x1 = r_x1[i_channel];
            o_x2 = r_x2[i_channel];
            o_y1 = r_y1[i_channel];
            o_y2 = r_y2[i_channel];
        end else begin
            o_x1 = i_x;
            o_x2 = i_x;
            o_y1 = i_x;
            o_y2 = i_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= '0;
        end else if (i_wr_en) begin
            r_primed[i_channel] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_x2[i_channel] <= o_x1;
            r_x1[i_channel] <= i_x;
            r_y2[i_channel] <= o_y1;
            r_y1[i_channel] <= i_wr_y;
        end
    end

endmodule

// ----- hdl/biq_mac.sv -----
`timescale 1ns / 1ps
// ============================================================================
// biq_mac
// Five products, their sum, floor to Q1.15 and saturation.
// ============================================================================
module biq_mac #(
    parameter int SAMPLE_WIDTH = biq_pkg::DEF_SAMPLE_WIDTH
) (
    input  biq_pkg::t_coefs                i_coefs,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x1,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x2,
    input  logic signed [SAMPLE_WIDTH-1:0] i_y1,
    input  logic signed [SAMPLE_WIDTH-1:0] i_y2,
    output logic signed [SAMPLE_WIDTH-1:0] o_y,
    output logic                           o_clip
);
    import biq_pkg::*;

    localparam int PROD_W = COEF_WIDTH + SAMPLE_WIDTH;
    localparam int ACC_W  = PROD_W + 3;
    localparam int YQ_W   = ACC_W - COEF_FRAC;

    localparam logic signed [SAMPLE_WIDTH-1:0] Y_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] Y_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
    logic signed [ACC_W-1:0]  acc;
    logic signed [YQ_W-1:0]   yq;
    logic                     in_range;

    assign p_b0 = i_coefs.b0 * i_x;
    assign p_b1 = i_coefs.b1 * i_x1;
    assign p_b2 = i_coefs.b2 * i_x2;
    assign p_a1 = i_coefs.a1 * i_y1;
    assign p_a2 = i_coefs.a2 * i_y2;

    assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
               - ACC_W'(p_a1) - ACC_W'(p_a2);

    // Dropping the low fraction bits of a two's complement value rounds
    // toward negative infinity.
    assign yq = acc[ACC_W-1:COEF_FRAC];

    // The value fits when all bits above the result's sign bit match it.
    assign in_range = (yq[YQ_W-1:SAMPLE_WIDTH-1] == '0) ||
                      (yq[YQ_W-1:SAMPLE_WIDTH-1] == '1);

    always_comb begin
        if (in_range) begin
            o_y    = yq[SAMPLE_WIDTH-1:0];
            o_clip = 1'b0;
        end else begin
            o_y    = yq[YQ_W-1] ? Y_MIN : Y_MAX;
            o_clip = 1'b1;
        end
    end

endmodule

// ----- hdl/biquad_df1_filter_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// biquad_df1_filter_unit
// Multi-channel second-order IIR filter, direct form 1, with saturation.
// ============================================================================
// Each request carries one sample of one channel and yields one result for
// that channel, y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2, with coefficients
// in signed Q2.16 and samples in signed Q1.15, rounded toward negative
// infinity and saturated (o_clipped flags saturation). The unit takes one
// request every clock cycle while the output is not stalled, any mix of
// channels. An accepted request is held in the input register and moves
// into the result register when that register is empty or being emptied.
// The cycle time is set by the per-channel history loop: history read, five
// multipliers, the sum and saturation back into history on one path. A
// request with sample_valid low is filtered as a zero sample, and the first
// request of a channel after reset fills that channel's history with its
// sample. A request for a channel at or beyond CHANNELS is accepted and
// discarded without a result. Coefficients are written through the
// configuration port, which is always ready and should only be used while
// the filter holds no requests in flight.
// ============================================================================
module biquad_df1_filter_unit #(
    parameter int CHANNELS     = biq_pkg::DEF_CHANNELS,
    parameter int SAMPLE_WIDTH = biq_pkg::DEF_SAMPLE_WIDTH,
    parameter int CH_WIDTH     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Sample requests.
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [CH_WIDTH-1:0]                 i_channel,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_sample,
    input  logic                                i_sample_valid,
    // Filtered results.
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [CH_WIDTH-1:0]                 o_out_channel,
    output logic signed [SAMPLE_WIDTH-1:0]      o_filtered,
    output logic                                o_clipped,
    // Coefficient writes.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [biq_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [biq_pkg::COEF_WIDTH-1:0]      i_cfg_data
);
    import biq_pkg::*;

    // Input register.
    logic                           r_in_valid, n_in_valid;
    logic [CH_WIDTH-1:0]            r_in_channel;
    logic signed [SAMPLE_WIDTH-1:0] r_in_x;

    // Result register.
    logic                           r_out_valid, n_out_valid;
    logic [CH_WIDTH-1:0]            r_out_channel;
    logic signed [SAMPLE_WIDTH-1:0] r_out_y;
    logic                           r_out_clip;

    logic                           in_accept;
    logic                           in_keep;
    logic                           advance;
    t_coefs                         coefs;
    logic signed [SAMPLE_WIDTH-1:0] x1, x2, y1, y2;
    logic signed [SAMPLE_WIDTH-1:0] y_new;
    logic                           clip_new;

    // The input register moves into the result register whenever the
    // result register is empty or being emptied this cycle.
    assign advance   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || advance;
    assign in_accept = i_valid && o_ready;
    // Requests for channels that do not exist are dropped on entry.
    assign in_keep   = in_accept && ({1'b0, i_channel} < (CH_WIDTH + 1)'(CHANNELS));

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = in_keep;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_keep) begin
            r_in_channel <= i_channel;
            r_in_x       <= i_sample_valid ? i_sample : '0;
        end
        if (advance) begin
            r_out_channel <= r_in_channel;
            r_out_y       <= y_new;
            r_out_clip    <= clip_new;
        end
    end

    biq_coef_regs u_coef_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_coefs    (coefs)
    );

    // History is updated in the same edge that captures the result, so a
    // following request for the same channel sees it in the next cycle.
    biq_history #(
        .CHANNELS     (CHANNELS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .CH_WIDTH     (CH_WIDTH)
    ) u_history (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_channel (r_in_channel),
        .i_x       (r_in_x),
        .i_wr_en   (advance),
        .i_wr_y    (y_new),
        .o_x1      (x1),
        .o_x2      (x2),
        .o_y1      (y1),
        .o_y2      (y2)
    );

    biq_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mac (
        .i_coefs (coefs),
        .i_x     (r_in_x),
        .i_x1    (x1),
        .i_x2    (x2),
        .i_y1    (y1),
        .i_y2    (y2),
        .o_y     (y_new),
        .o_clip  (clip_new)
    );

    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_out_valid;
    assign o_out_channel = r_out_channel;
    assign o_filtered    = r_out_y;
    assign o_clipped     = r_out_clip;

endmodule

// ----- hdl/biq_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// biq_checker
// Port-level checks for the biquad filter unit, bound to the top level.
// ============================================================================
module biq_checker #(
    parameter int SAMPLE_WIDTH = biq_pkg::DEF_SAMPLE_WIDTH,
    parameter int CH_WIDTH     = 2
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_ready,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic [CH_WIDTH-1:0]            o_out_channel,
    input logic signed [SAMPLE_WIDTH-1:0] o_filtered,
    input logic                           o_clipped
);
    import biq_pkg::*;

    localparam logic signed [SAMPLE_WIDTH-1:0] Y_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] Y_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_filtered)
                                && $stable(o_out_channel) && $stable(o_clipped))
        else $error("stalled result changed");

    // A saturated result is one of the two range limits.
    a_clip_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_clipped |-> (o_filtered == Y_MAX) || (o_filtered == Y_MIN))
        else $error("clipped result is not a range limit");

    // Requests are only refused while a result is held by the consumer.
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input refused without an output stall");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

endmodule

bind biquad_df1_filter_unit biq_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .CH_WIDTH     (CH_WIDTH)
) u_biq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_out_channel (o_out_channel),
    .o_filtered    (o_filtered),
    .o_clipped     (o_clipped)
);
